// ===== rtl/hse_pkg.sv =====
package hse_pkg;

  // width and ceiling of the reported swap count
  localparam int unsigned SwapW = 12;
  localparam logic [SwapW-1:0] SwapMax = '1;

  // source of the word written into the heap store
  typedef enum logic [1:0] {
    WS_INPUT,
    WS_SIFT,
    WS_LEFT,
    WS_RDATA
  } wsel_e;

  // controller to datapath
  typedef struct packed {
    logic  we;
    wsel_e wsel;
    logic  ld_sift;
    logic  ld_left;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic left_gt_sift;
    logic right_gt_left;
    logic right_gt_sift;
  } sts_t;

endpackage

// ===== rtl/heap_sort_engine.sv =====
// heap sort engine: sorts a set of signed words in ascending order
// input: a word is taken at a rising edge with start_i high and busy_o low;
//   value_i is stored in arrival order, is_last_i closes the set and starts
//   the sort. words beyond DEPTH are dropped and reported on overflowed_o
// output: one word per stored element, each valid for exactly one cycle
//   while strobe_o is high; the receiver cannot hold results off.
//   end_of_run_o marks the final word, which also carries swap_count_o
//   (sift-down swaps, saturating) and overflowed_o; both read 0 otherwise
// timing: loading accepts one word per cycle. after is_last each sift-down
//   reads the left child, then the right child, and compares both with the
//   sifted word at each node that has children; it writes the sifted word
//   back where it stops. the pace is set by the single-port heap store
//   read through a register.
//   results then stream at one per cycle, and busy_o falls at the edge that
//   ends the final word, from then on the next set may load
// reset: asynchronous, active low; clears count, swap count and drop flag,
//   the store contents are left as they are and only written entries are used
module heap_sort_engine #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // load side
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [31:0]            value_i,
  input  logic                          is_last_i,
  // result side
  output logic                          strobe_o,
  output logic signed [31:0]            sorted_value_o,
  output logic                          end_of_run_o,
  output logic [hse_pkg::SwapW-1:0]     swap_count_o,
  output logic                          overflowed_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hse_pkg::cmd_t cmd;
  hse_pkg::sts_t sts;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // sequencer: load, heap build, root extraction, in-order readout
  hse_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .is_last_i    (is_last_i),
    .busy_o       (busy_o),
    .cmd_o        (cmd),
    .waddr_o      (waddr),
    .raddr_o      (raddr),
    .sts_i        (sts),
    .strobe_o     (strobe_o),
    .end_of_run_o (end_of_run_o),
    .swap_count_o (swap_count_o),
    .overflowed_o (overflowed_o)
  );

  // heap store, sifted word, held left child and the child compares
  hse_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .value_i (value_i),
    .sts_o   (sts),
    .rdata_o (sorted_value_o)
  );

endmodule

// ===== rtl/hse_dpath.sv =====
module hse_dpath #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  hse_pkg::cmd_t            cmd_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [AW-1:0]            raddr_i,
  input  logic signed [31:0]       value_i,
  output hse_pkg::sts_t            sts_o,
  output logic signed [31:0]       rdata_o
);

  logic signed [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_q;
  logic signed [DATA_WIDTH-1:0] sift_q;
  logic signed [DATA_WIDTH-1:0] left_q;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic signed [DATA_WIDTH-1:0] in_word;

  // keep the low bits, sign-extend when the store is wider than the port
  assign in_word = DATA_WIDTH'(value_i);

  always_comb begin
    case (cmd_i.wsel)
      hse_pkg::WS_INPUT: wdata = in_word;
      hse_pkg::WS_SIFT:  wdata = sift_q;
      hse_pkg::WS_LEFT:  wdata = left_q;
      hse_pkg::WS_RDATA: wdata = rd_q;
      default:           wdata = rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sift) begin
      sift_q <= rd_q;
    end
    if (cmd_i.ld_left) begin
      left_q <= rd_q;
    end
  end

  // right child is on the read register while the left one is held
  assign sts_o.left_gt_sift  = left_q > sift_q;
  assign sts_o.right_gt_left = rd_q > left_q;
  assign sts_o.right_gt_sift = rd_q > sift_q;

  // results leave zero-extended to the port width
  assign rdata_o = 32'($unsigned(rd_q));

endmodule

// ===== rtl/hse_ctrl.sv =====
module hse_ctrl #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         is_last_i,
  output logic                         busy_o,
  output hse_pkg::cmd_t                cmd_o,
  output logic [AW-1:0]                waddr_o,
  output logic [AW-1:0]                raddr_o,
  input  hse_pkg::sts_t                sts_i,
  output logic                         strobe_o,
  output logic                         end_of_run_o,
  output logic [hse_pkg::SwapW-1:0]    swap_count_o,
  output logic                         overflowed_o
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BD_RD,
    ST_BD_LD,
    ST_SF_RL,
    ST_SF_RR,
    ST_SF_LL,
    ST_SF_CMP,
    ST_EX_R0,
    ST_EX_RE,
    ST_EX_LD,
    ST_EMIT,
    ST_FIN
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             size_q, size_d;
  logic [CW-1:0]             ek_q, ek_d;
  logic [AW-1:0]             node_q, node_d;
  logic                      build_q, build_d;
  logic [hse_pkg::SwapW-1:0] swap_q, swap_d;
  logic                      drop_q, drop_d;
  logic                      strobe_q, strobe_d;
  logic                      last_q, last_d;

  logic [AW+1:0]             left_w, right_w, size_w;
  logic                      left_ok, right_ok, take_r, take;
  logic [CW-1:0]             idx_m1, cnt_inc;
  logic                      room;

  assign left_w   = {1'b0, node_q, 1'b1};
  assign right_w  = left_w + 1'b1;
  assign size_w   = (AW + 2)'(size_q);
  assign left_ok  = left_w < size_w;
  assign right_ok = right_w < size_w;
  assign take_r   = right_ok & (sts_i.left_gt_sift ? sts_i.right_gt_left
                                                   : sts_i.right_gt_sift);
  assign take     = sts_i.left_gt_sift | take_r;
  assign idx_m1   = idx_q - 1'b1;
  assign room     = cnt_q < CW'(DEPTH);
  assign cnt_inc  = room ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    size_d   = size_q;
    ek_d     = ek_q;
    node_d   = node_q;
    build_d  = build_q;
    swap_d   = swap_q;
    drop_d   = drop_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    cmd_o    = '{we: 1'b0, wsel: hse_pkg::WS_INPUT, ld_sift: 1'b0, ld_left: 1'b0};
    waddr_o  = node_q;
    raddr_o  = node_q;

    case (state_q)
      ST_LOAD: begin
        waddr_o = AW'(cnt_q);
        if (start_i) begin
          cmd_o.we = room;
          cnt_d    = cnt_inc;
          if (!room) begin
            drop_d = 1'b1;
          end
          if (is_last_i) begin
            if ((cnt_inc >> 1) == '0) begin
              ek_d    = '0;
              state_d = ST_EMIT;
            end else begin
              idx_d   = cnt_inc >> 1;
              build_d = 1'b1;
              state_d = ST_BD_RD;
            end
          end
        end
      end
      ST_BD_RD: begin
        raddr_o = AW'(idx_m1);
        state_d = ST_BD_LD;
      end
      ST_BD_LD: begin
        cmd_o.ld_sift = 1'b1;
        node_d        = AW'(idx_m1);
        size_d        = cnt_q;
        state_d       = ST_SF_RL;
      end
      ST_SF_RL: begin
        raddr_o = AW'(left_w);
        if (left_ok) begin
          state_d = ST_SF_RR;
        end else begin
          cmd_o.we   = 1'b1;
          cmd_o.wsel = hse_pkg::WS_SIFT;
          state_d    = ST_EX_R0;  // replaced below by the sift-done branch
        end
      end
      ST_SF_RR: begin
        // left child is on the read register now
        raddr_o       = AW'(right_w);
        cmd_o.ld_left = 1'b1;
        state_d       = ST_SF_LL;
      end
      ST_SF_LL: begin
        // keep the right child on the read register for the compare
        raddr_o = AW'(right_w);
        state_d = ST_SF_CMP;
      end
      ST_SF_CMP: begin
        cmd_o.we = 1'b1;
        if (take) begin
          cmd_o.wsel = take_r ? hse_pkg::WS_RDATA : hse_pkg::WS_LEFT;
          node_d     = take_r ? AW'(right_w) : AW'(left_w);
          if (swap_q != hse_pkg::SwapMax) begin
            swap_d = swap_q + 1'b1;
          end
          state_d = ST_SF_RL;
        end else begin
          cmd_o.wsel = hse_pkg::WS_SIFT;
        end
      end
      ST_EX_R0: begin
        raddr_o = '0;
        state_d = ST_EX_RE;
      end
      ST_EX_RE: begin
        // old root goes to the heap end, the end word comes back for the sift
        raddr_o    = AW'(idx_m1);
        waddr_o    = AW'(idx_m1);
        cmd_o.we   = 1'b1;
        cmd_o.wsel = hse_pkg::WS_RDATA;
        state_d    = ST_EX_LD;
      end
      ST_EX_LD: begin
        cmd_o.ld_sift = 1'b1;
        node_d        = '0;
        size_d        = idx_m1;
        build_d       = 1'b0;
        state_d       = ST_SF_RL;
      end
      ST_EMIT: begin
        raddr_o  = AW'(ek_q);
        strobe_d = 1'b1;
        last_d   = (ek_q == cnt_q - 1'b1);
        ek_d     = ek_q + 1'b1;
        if (ek_q == cnt_q - 1'b1) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cnt_d   = '0;
        swap_d  = '0;
        drop_d  = 1'b0;
        state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // end of one sift-down: step the build or extraction loop
    if ((state_q == ST_SF_RL && !left_ok) || (state_q == ST_SF_CMP && !take)) begin
      idx_d = idx_m1;
      if (build_q) begin
        if (idx_m1 == '0) begin
          idx_d = cnt_q;
          if (cnt_q > CW'(1)) begin
            state_d = ST_EX_R0;
          end else begin
            ek_d    = '0;
            state_d = ST_EMIT;
          end
        end else begin
          state_d = ST_BD_RD;
        end
      end else if (idx_m1 > CW'(1)) begin
        state_d = ST_EX_R0;
      end else begin
        ek_d    = '0;
        state_d = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      idx_q    <= '0;
      size_q   <= '0;
      ek_q     <= '0;
      node_q   <= '0;
      build_q  <= 1'b0;
      swap_q   <= '0;
      drop_q   <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      size_q   <= size_d;
      ek_q     <= ek_d;
      node_q   <= node_d;
      build_q  <= build_d;
      swap_q   <= swap_d;
      drop_q   <= drop_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  assign busy_o       = state_q != ST_LOAD;
  assign strobe_o     = strobe_q;
  assign end_of_run_o = last_q;
  assign swap_count_o = last_q ? swap_q : '0;
  assign overflowed_o = last_q & drop_q;

endmodule
